FILE: rtl/core/iecatp_pkg.sv
// ----------------------------------------------------------------------------
// iecatp_pkg
// Shared types and constants for the direct-address token parser.
// ----------------------------------------------------------------------------
`default_nettype none

package iecatp_pkg;

  // Width of the process-image index, which sets the byte index limit.
  localparam int unsigned IndexBits = 16;
  localparam int unsigned IndexLimit =
    (IndexBits >= 16) ? 32'd65535 : ((32'd1 << IndexBits) - 32'd1);

  // Largest legal bit number inside a byte.
  localparam logic [6:0] BitLimit = 7'd7;

  // Characters of the token grammar; letters are compared after OR with 0x20.
  localparam logic [7:0] ChTerm    = 8'h00;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChLowI    = 8'h69;
  localparam logic [7:0] ChLowQ    = 8'h71;
  localparam logic [7:0] ChLowX    = 8'h78;
  localparam logic [7:0] ChLowB    = 8'h62;
  localparam logic [7:0] ChLowW    = 8'h77;
  localparam logic [7:0] ChLowD    = 8'h64;
  localparam logic [7:0] ChLowL    = 8'h6C;
  localparam logic [7:0] CaseBit   = 8'h20;

  // Bit index reported for sizes other than a single bit.
  localparam logic signed [3:0] NoBitIndex = -4'sd1;

  typedef enum logic [2:0] {
    PH_PERCENT  = 3'd0,
    PH_DIR      = 3'd1,
    PH_SIZE     = 3'd2,
    PH_FIRSTDIG = 3'd3,
    PH_BYTEDIG  = 3'd4,
    PH_BITFIRST = 3'd5,
    PH_BITDIG   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    SZ_X = 3'd0,
    SZ_B = 3'd1,
    SZ_W = 3'd2,
    SZ_D = 3'd3,
    SZ_L = 3'd4
  } size_e;

  typedef struct packed {
    phase_e      phase;
    logic        dir;
    size_e       size;
    logic [15:0] byte_acc;
    logic [3:0]  bit_acc;
    logic        err;
  } pstate_t;

  typedef struct packed {
    logic              valid_res;
    logic              is_output;
    logic [2:0]        size_code;
    logic [15:0]       byte_addr;
    logic signed [3:0] bit_pos;
  } result_t;

  localparam pstate_t StateReset = '{
    phase:    PH_PERCENT,
    dir:      1'b0,
    size:     SZ_X,
    byte_acc: 16'd0,
    bit_acc:  4'd0,
    err:      1'b0
  };

endpackage

`default_nettype wire

FILE: rtl/core/iecatp_step.sv
// ----------------------------------------------------------------------------
// iecatp_step
// Combinational parser step: next state and result for one character.
// ----------------------------------------------------------------------------
`default_nettype none

module iecatp_step (
  input  var iecatp_pkg::pstate_t st_i,
  input  wire logic [7:0]         ch_i,
  output var iecatp_pkg::pstate_t st_o,
  output var iecatp_pkg::result_t res_o
);

  logic               term;
  logic [7:0]         low;
  logic               is_dig;
  logic [3:0]         digit;
  logic [19:0]        byte_v;
  logic [6:0]         bit_v;
  logic               byte_ovf;
  logic               bit_ovf;
  iecatp_pkg::phase_e phase_d;
  logic               ok;

  assign term   = (ch_i == iecatp_pkg::ChTerm);
  assign low    = ch_i | iecatp_pkg::CaseBit;
  assign is_dig = (ch_i >= iecatp_pkg::ChZero) && (ch_i <= iecatp_pkg::ChNine);
  assign digit  = ch_i[3:0];

  // Multiply by ten as two shifts and an add.
  assign byte_v = ({4'd0, st_i.byte_acc} << 3) + ({4'd0, st_i.byte_acc} << 1)
                + {16'd0, digit};
  assign bit_v  = ({3'd0, st_i.bit_acc} << 3) + ({3'd0, st_i.bit_acc} << 1)
                + {3'd0, digit};
  assign byte_ovf = (byte_v > 20'(iecatp_pkg::IndexLimit));
  assign bit_ovf  = (bit_v > iecatp_pkg::BitLimit);

  // Next phase.
  always_comb begin
    phase_d = st_i.phase;
    case (st_i.phase)
      iecatp_pkg::PH_PERCENT: begin
        if (ch_i == iecatp_pkg::ChPercent) phase_d = iecatp_pkg::PH_DIR;
      end
      iecatp_pkg::PH_DIR: begin
        if (low == iecatp_pkg::ChLowI || low == iecatp_pkg::ChLowQ) begin
          phase_d = iecatp_pkg::PH_SIZE;
        end
      end
      iecatp_pkg::PH_SIZE: begin
        if (low == iecatp_pkg::ChLowX || low == iecatp_pkg::ChLowB ||
            low == iecatp_pkg::ChLowW || low == iecatp_pkg::ChLowD ||
            low == iecatp_pkg::ChLowL) begin
          phase_d = iecatp_pkg::PH_FIRSTDIG;
        end
      end
      iecatp_pkg::PH_FIRSTDIG: begin
        if (is_dig) phase_d = iecatp_pkg::PH_BYTEDIG;
      end
      iecatp_pkg::PH_BYTEDIG: begin
        if (!is_dig && ch_i == iecatp_pkg::ChDot && st_i.size == iecatp_pkg::SZ_X) begin
          phase_d = iecatp_pkg::PH_BITFIRST;
        end
      end
      iecatp_pkg::PH_BITFIRST, iecatp_pkg::PH_BITDIG: begin
        if (is_dig) phase_d = iecatp_pkg::PH_BITDIG;
      end
      default: begin
        phase_d = st_i.phase;
      end
    endcase
  end

  // Datapath registers and the sticky error flag.
  always_comb begin
    st_o = st_i;
    if (term) begin
      st_o = iecatp_pkg::StateReset;
    end else if (!st_i.err) begin
      st_o.phase = phase_d;
      case (st_i.phase)
        iecatp_pkg::PH_PERCENT: begin
          if (ch_i != iecatp_pkg::ChPercent) st_o.err = 1'b1;
        end
        iecatp_pkg::PH_DIR: begin
          if (low == iecatp_pkg::ChLowI) st_o.dir = 1'b0;
          else if (low == iecatp_pkg::ChLowQ) st_o.dir = 1'b1;
          else st_o.err = 1'b1;
        end
        iecatp_pkg::PH_SIZE: begin
          if (low == iecatp_pkg::ChLowX) st_o.size = iecatp_pkg::SZ_X;
          else if (low == iecatp_pkg::ChLowB) st_o.size = iecatp_pkg::SZ_B;
          else if (low == iecatp_pkg::ChLowW) st_o.size = iecatp_pkg::SZ_W;
          else if (low == iecatp_pkg::ChLowD) st_o.size = iecatp_pkg::SZ_D;
          else if (low == iecatp_pkg::ChLowL) st_o.size = iecatp_pkg::SZ_L;
          else st_o.err = 1'b1;
        end
        iecatp_pkg::PH_FIRSTDIG, iecatp_pkg::PH_BYTEDIG: begin
          if (is_dig) begin
            if (byte_ovf) st_o.err = 1'b1;
            else st_o.byte_acc = byte_v[15:0];
          end else if (st_i.phase == iecatp_pkg::PH_FIRSTDIG ||
                       ch_i != iecatp_pkg::ChDot || st_i.size != iecatp_pkg::SZ_X) begin
            st_o.err = 1'b1;
          end
        end
        iecatp_pkg::PH_BITFIRST, iecatp_pkg::PH_BITDIG: begin
          if (is_dig) begin
            if (bit_ovf) st_o.err = 1'b1;
            else st_o.bit_acc = bit_v[3:0];
          end else begin
            st_o.err = 1'b1;
          end
        end
        default: begin
          st_o.err = 1'b1;
        end
      endcase
    end
  end

  // Result for a terminator; an ill-formed token reports all zeros.
  assign ok = !st_i.err && (st_i.phase == iecatp_pkg::PH_BYTEDIG ||
                            st_i.phase == iecatp_pkg::PH_BITDIG);

  always_comb begin
    res_o = '0;
    if (ok) begin
      res_o.valid_res = 1'b1;
      res_o.is_output = st_i.dir;
      res_o.size_code = st_i.size;
      res_o.byte_addr = st_i.byte_acc;
      res_o.bit_pos   = (st_i.size == iecatp_pkg::SZ_X) ? $signed(st_i.bit_acc)
                                                        : iecatp_pkg::NoBitIndex;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/iec_address_token_parser_core.sv
// ----------------------------------------------------------------------------
// iec_address_token_parser_core
// Parses direct-address tokens one character word at a time.
// ----------------------------------------------------------------------------
// The result of a terminator is registered and is on the outputs in the cycle
// after it is accepted. Throughput: one character word per cycle unless an
// unread result stalls input; the parse state and the result register update
// in the same cycle. Reset clears the parse state to "expect percent sign" and
// clears the output valid flag; the result register itself is not reset.
`default_nettype none

module iec_address_token_parser_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output wire logic              in_ready_o,
  input  wire logic [7:0]        ch_i,
  output wire logic              out_valid_o,
  input  wire logic              out_ready_i,
  output wire logic              valid_res_o,
  output wire logic              is_output_o,
  output wire logic [2:0]        size_code_o,
  output wire logic [15:0]       byte_addr_o,
  output wire logic signed [3:0] bit_pos_o
);

  iecatp_pkg::pstate_t st_q;
  iecatp_pkg::pstate_t st_d;
  iecatp_pkg::result_t res_d;
  iecatp_pkg::result_t res_q;
  logic                out_valid_q;
  logic                accept;
  logic                term;

  iecatp_step u_step (
    .st_i  (st_q),
    .ch_i  (ch_i),
    .st_o  (st_d),
    .res_o (res_d)
  );

  // A waiting result only blocks input when it is not taken this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign term       = (ch_i == iecatp_pkg::ChTerm);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= iecatp_pkg::StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) st_q <= st_d;
      if (accept && term) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && term) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q.valid_res;
  assign is_output_o = res_q.is_output;
  assign size_code_o = res_q.size_code;
  assign byte_addr_o = res_q.byte_addr;
  assign bit_pos_o   = res_q.bit_pos;

  // A terminator always leaves the parser in its starting state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && term |=> st_q.phase == iecatp_pkg::PH_PERCENT && !st_q.err)
    else $error("parser state not cleared after terminator");

  // Only a terminator produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !term && !out_valid_q |=> !out_valid_q)
    else $error("result produced without terminator");

  // A rejected token reports all fields as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |->
      !is_output_o && size_code_o == 3'd0 && byte_addr_o == 16'd0 &&
      bit_pos_o == 4'sd0)
    else $error("invalid result carries nonzero fields");

  // Sizes other than a single bit report no bit index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o && size_code_o != iecatp_pkg::SZ_X |->
      bit_pos_o == iecatp_pkg::NoBitIndex)
    else $error("bit index reported for non-bit size");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds direct-address tokens to the token parser one character word at a time
// and checks every decoded address against a table row or a parser model kept
// here. A table of hand-picked tokens runs first. Random tokens follow: mostly
// well formed, some broken, some noise. Both handshakes stall at random.
// ----------------------------------------------------------------------------

module testbench;

  typedef struct {
    string               text;
    bit                  typed;
    iecatp_pkg::result_t want;
  } token_row_t;

  localparam iecatp_pkg::result_t BadToken = '0;
  localparam logic [7:0] SizeLetter [5] = '{
    iecatp_pkg::ChLowX, iecatp_pkg::ChLowB, iecatp_pkg::ChLowW,
    iecatp_pkg::ChLowD, iecatp_pkg::ChLowL
  };
  localparam int NumRows = 25;

  // Rows with typed set carry the expected address; the others use the model.
  token_row_t dir_tbl [NumRows] = '{
    '{"",            1'b1, BadToken},
    '{"%QL65535",    1'b1,
      '{1'b1, 1'b1, iecatp_pkg::SZ_L, 16'd65535, iecatp_pkg::NoBitIndex}},
    '{"%IX0",        1'b1, '{1'b1, 1'b0, iecatp_pkg::SZ_X, 16'd0, 4'sd0}},
    '{"%QX12.7",     1'b1, '{1'b1, 1'b1, iecatp_pkg::SZ_X, 16'd12, 4'sd7}},
    '{"%ix007.07",   1'b0, BadToken},
    '{"%IB255",      1'b0, BadToken},
    '{"%qw0",        1'b0, BadToken},
    '{"%Id4096",     1'b0, BadToken},
    '{"%Ql00000",    1'b0, BadToken},
    '{"%IX2.0",      1'b0, BadToken},
    '{"%QD65535",    1'b0, BadToken},
    '{"%QW65536",    1'b1, BadToken},
    '{"%IW99999999", 1'b1, BadToken},
    '{"%IX3.8",      1'b1, BadToken},
    '{"%IX1.17",     1'b1, BadToken},
    '{"%IB1.2",      1'b1, BadToken},
    '{"%IX3.",       1'b1, BadToken},
    '{"%I",          1'b1, BadToken},
    '{"%",           1'b1, BadToken},
    '{"%QW",         1'b1, BadToken},
    '{"QW5",         1'b1, BadToken},
    '{"%AW5",        1'b1, BadToken},
    '{"%IZ5",        1'b1, BadToken},
    '{"%IW5x9.1",    1'b1, BadToken},
    '{"%\200X\377",  1'b1, BadToken}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [7:0]        ch_i = 8'h00;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              valid_res_o;
  logic              is_output_o;
  logic [2:0]        size_code_o;
  logic [15:0]       byte_addr_o;
  logic signed [3:0] bit_pos_o;

  iec_address_token_parser_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .valid_res_o (valid_res_o),
    .is_output_o (is_output_o),
    .size_code_o (size_code_o),
    .byte_addr_o (byte_addr_o),
    .bit_pos_o   (bit_pos_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Parser model state.
  iecatp_pkg::phase_e tp_phase = iecatp_pkg::PH_PERCENT;
  logic               tp_dir = 1'b0;
  iecatp_pkg::size_e  tp_size = iecatp_pkg::SZ_X;
  logic [15:0]        tp_byte = '0;
  logic [3:0]         tp_bit = '0;
  logic               tp_err = 1'b0;

  iecatp_pkg::result_t addr_q [$];
  int                  stall_pct = 36;
  int                  errors = 0;
  int                  chars_sent = 0;
  int                  tokens_sent = 0;
  int                  addrs_seen = 0;
  int                  good_addrs = 0;

  // Advances the model by one character; returns 1 on a terminator, with the
  // decoded address in res, all zeros for an ill-formed token.
  function automatic bit parse_char(input logic [7:0] c,
                                    output iecatp_pkg::result_t res);
    logic [7:0]  low;
    int unsigned v;
    bit          is_dig;
    res = '0;
    low = c | iecatp_pkg::CaseBit;
    is_dig = (c >= iecatp_pkg::ChZero) && (c <= iecatp_pkg::ChNine);
    if (c == iecatp_pkg::ChTerm) begin
      if (!tp_err && (tp_phase == iecatp_pkg::PH_BYTEDIG ||
                      tp_phase == iecatp_pkg::PH_BITDIG)) begin
        res.valid_res = 1'b1;
        res.is_output = tp_dir;
        res.size_code = tp_size;
        res.byte_addr = tp_byte;
        res.bit_pos   = (tp_size == iecatp_pkg::SZ_X) ? tp_bit : iecatp_pkg::NoBitIndex;
      end
      tp_phase = iecatp_pkg::PH_PERCENT;
      tp_dir   = 1'b0;
      tp_size  = iecatp_pkg::SZ_X;
      tp_byte  = '0;
      tp_bit   = '0;
      tp_err   = 1'b0;
      return 1'b1;
    end
    if (tp_err) return 1'b0;
    case (tp_phase)
      iecatp_pkg::PH_PERCENT: begin
        if (c == iecatp_pkg::ChPercent) tp_phase = iecatp_pkg::PH_DIR;
        else tp_err = 1'b1;
      end
      iecatp_pkg::PH_DIR: begin
        if (low == iecatp_pkg::ChLowI) begin
          tp_dir = 1'b0;
          tp_phase = iecatp_pkg::PH_SIZE;
        end else if (low == iecatp_pkg::ChLowQ) begin
          tp_dir = 1'b1;
          tp_phase = iecatp_pkg::PH_SIZE;
        end else begin
          tp_err = 1'b1;
        end
      end
      iecatp_pkg::PH_SIZE: begin
        tp_phase = iecatp_pkg::PH_FIRSTDIG;
        case (low)
          iecatp_pkg::ChLowX: tp_size = iecatp_pkg::SZ_X;
          iecatp_pkg::ChLowB: tp_size = iecatp_pkg::SZ_B;
          iecatp_pkg::ChLowW: tp_size = iecatp_pkg::SZ_W;
          iecatp_pkg::ChLowD: tp_size = iecatp_pkg::SZ_D;
          iecatp_pkg::ChLowL: tp_size = iecatp_pkg::SZ_L;
          default: begin
            tp_err = 1'b1;
            tp_phase = iecatp_pkg::PH_SIZE;
          end
        endcase
      end
      iecatp_pkg::PH_FIRSTDIG, iecatp_pkg::PH_BYTEDIG: begin
        if (is_dig) begin
          v = tp_byte * 10 + (c - iecatp_pkg::ChZero);
          if (v > iecatp_pkg::IndexLimit) tp_err = 1'b1;
          else tp_byte = v[15:0];
          tp_phase = iecatp_pkg::PH_BYTEDIG;
        end else if (tp_phase == iecatp_pkg::PH_BYTEDIG && c == iecatp_pkg::ChDot &&
                     tp_size == iecatp_pkg::SZ_X) begin
          tp_phase = iecatp_pkg::PH_BITFIRST;
        end else begin
          tp_err = 1'b1;
        end
      end
      iecatp_pkg::PH_BITFIRST, iecatp_pkg::PH_BITDIG: begin
        if (is_dig) begin
          v = tp_bit * 10 + (c - iecatp_pkg::ChZero);
          if (v > iecatp_pkg::BitLimit) tp_err = 1'b1;
          else tp_bit = v[3:0];
          tp_phase = iecatp_pkg::PH_BITDIG;
        end else begin
          tp_err = 1'b1;
        end
      end
      default: tp_err = 1'b1;
    endcase
    return 1'b0;
  endfunction

  // Called right after a rising edge; returns right after the edge that took
  // the word.
  task automatic send_char(input logic [7:0] c, input bit typed,
                           input iecatp_pkg::result_t want);
    iecatp_pkg::result_t res;
    bit                  took;
    if ($urandom_range(99) < stall_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < stall_pct);
    end
    in_valid_i <= 1'b1;
    ch_i <= c;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    chars_sent++;
    if (parse_char(c, res)) begin
      addr_q.push_back(typed ? want : res);
      tokens_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (addr_q.size() != 0);
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  iecatp_pkg::result_t got_r;

  // Inputs only move at rising edges, so a handshake seen here completes at
  // the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (addr_q.size() == 0) begin
        errors++;
        $display("%0t ns: address word with nothing expected, actual %b %b %0d %0d %0d",
                 $time, valid_res_o, is_output_o, size_code_o, byte_addr_o, bit_pos_o);
      end else begin
        got_r = addr_q.pop_front();
        check_field("valid_res", 16'(valid_res_o), 16'(got_r.valid_res));
        check_field("is_output", 16'(is_output_o), 16'(got_r.is_output));
        check_field("size_code", 16'(size_code_o), 16'(got_r.size_code));
        check_field("byte_addr", byte_addr_o, got_r.byte_addr);
        check_field("bit_pos", 16'(unsigned'(bit_pos_o)),
                    16'(unsigned'(got_r.bit_pos)));
        addrs_seen++;
        if (got_r.valid_res) good_addrs++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [7:0] tok [$];
    logic [7:0] lc;
    string      digits;
    int         kind;
    int         val;
    int         pos;
    int         sz;
    int         rand_chars;
    int         ntok;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[r]) begin
      for (int i = 0; i < dir_tbl[r].text.len(); i++) begin
        send_char(dir_tbl[r].text[i], 1'b0, BadToken);
      end
      send_char(iecatp_pkg::ChTerm, dir_tbl[r].typed, dir_tbl[r].want);
    end
    wait_drained();

    rand_chars = 0;
    ntok = 0;
    while (rand_chars < 1600) begin
      // A long run with both sides streaming at full rate.
      stall_pct = (ntok >= 100 && ntok < 160) ? 0 : 36;
      if (ntok == 220) wait_drained();
      tok.delete();
      kind = $urandom_range(99);
      if (kind < 15) begin
        repeat ($urandom_range(6, 1)) tok.push_back(8'($urandom_range(255, 1)));
      end else begin
        tok.push_back(iecatp_pkg::ChPercent);
        lc = $urandom_range(1) ? iecatp_pkg::ChLowQ : iecatp_pkg::ChLowI;
        tok.push_back($urandom_range(1) ? lc : (lc & ~iecatp_pkg::CaseBit));
        sz = $urandom_range(4);
        lc = SizeLetter[sz];
        tok.push_back($urandom_range(1) ? lc : (lc & ~iecatp_pkg::CaseBit));
        case ($urandom_range(3))
          0: val = $urandom_range(9);
          1: val = $urandom_range(999);
          2: val = $urandom_range(65535, 65530);
          default: val = $urandom_range(70000);
        endcase
        digits = $sformatf("%0d", val);
        if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) digits = {"0", digits};
        for (int i = 0; i < digits.len(); i++) tok.push_back(digits[i]);
        if (sz == 0 && $urandom_range(3) != 0) begin
          tok.push_back(iecatp_pkg::ChDot);
          if ($urandom_range(4) == 0) tok.push_back(iecatp_pkg::ChZero);
          val = ($urandom_range(3) == 0) ? $urandom_range(9) : $urandom_range(7);
          tok.push_back(iecatp_pkg::ChZero + 8'(val));
        end
        // Roughly three in ten of the formed tokens get broken on purpose.
        if (kind < 40) begin
          pos = $urandom_range(tok.size() - 1);
          case ($urandom_range(4))
            0: tok[pos] = 8'($urandom_range(255, 1));
            1: tok = tok[0:pos];
            2: tok.insert(pos, 8'($urandom_range(255, 1)));
            3: tok.push_back(iecatp_pkg::ChZero + 8'($urandom_range(9)));
            default: begin
              tok.push_back(iecatp_pkg::ChDot);
              tok.push_back(iecatp_pkg::ChZero + 8'($urandom_range(9)));
            end
          endcase
        end
      end
      foreach (tok[i]) send_char(tok[i], 1'b0, BadToken);
      send_char(iecatp_pkg::ChTerm, 1'b0, BadToken);
      rand_chars += tok.size() + 1;
      ntok++;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d character words in %0d tokens (%0d table rows, %0d random).",
             chars_sent, tokens_sent, NumRows, ntok);
    $display("Checked %0d addresses, %0d of them well formed, with %0d mismatches.",
             addrs_seen, good_addrs, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/iecatp_pkg.sv
rtl/core/iecatp_step.sv
rtl/core/iec_address_token_parser_core.sv
verif/testbench.sv
